// ----- rtl/core/sonar_wander_velocity_law_top_macros.svh -----
// assertion macros of the sonar wander velocity law rtl
`ifndef SONAR_WANDER_VELOCITY_LAW_TOP_MACROS_SVH
`define SONAR_WANDER_VELOCITY_LAW_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SWV_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define SWV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define SWV_ASSERT(lbl, clk, rst_n, expr)
`define SWV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/swv_pkg.sv -----
// shared types and constants of the sonar wander velocity law
package swv_pkg;
    typedef enum logic [1:0] {
        MODE_STALE   = 2'd0,
        MODE_CRUISE  = 2'd1,
        MODE_CAUTION = 2'd2,
        MODE_DANGER  = 2'd3
    } t_mode;

    localparam logic [1:0] CFG_GAIN   = 2'd0;
    localparam logic [1:0] CFG_SAFE   = 2'd1;
    localparam logic [1:0] CFG_TOL    = 2'd2;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [15:0] GAIN_RST = 16'd256;
    localparam logic [15:0] SAFE_RST = 16'd256;
    localparam logic [15:0] TOL_RST  = 16'd26;

    localparam logic [15:0] DANGER_VX = 16'hF600;
    localparam logic [15:0] DANGER_WZ = 16'h0A00;

    localparam int Q_W          = 17;
    localparam int FRONT_STAGES = 4;
    localparam int DIV_STAGES   = Q_W + 1;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

    localparam int VNUM_W = 49;
    localparam int VDEN_W = 28;
    localparam int WNUM_W = 33;
    localparam int WDEN_W = 20;

    typedef struct packed {
        t_mode mode;
        logic  neg;
        logic  den_zero;
        logic  num_nz;
    } t_vside;

    typedef struct packed {
        logic neg;
        logic den_zero;
        logic num_nz;
    } t_wside;
endpackage

// ----- rtl/core/swv_in_if.sv -----
// sonar set input channel
interface swv_in_if;
    logic        valid;
    logic        ready;
    logic        readings_fresh;
    logic [15:0] left_outer_dist;
    logic [15:0] left_mid_dist;
    logic [15:0] front_left_dist;
    logic [15:0] front_right_dist;
    logic [15:0] right_mid_dist;
    logic [15:0] right_outer_dist;
    modport source (output valid, readings_fresh, left_outer_dist, left_mid_dist,
        front_left_dist, front_right_dist, right_mid_dist, right_outer_dist, input ready);
    modport sink (input valid, readings_fresh, left_outer_dist, left_mid_dist,
        front_left_dist, front_right_dist, right_mid_dist, right_outer_dist, output ready);
endinterface

// ----- rtl/core/swv_out_if.sv -----
// velocity command output channel
interface swv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] forward_velocity;
    logic signed [15:0] turn_rate;
    logic [1:0]         drive_mode;
    logic               saturated;
    modport source (output valid, forward_velocity, turn_rate, drive_mode, saturated,
        input ready);
    modport sink (input valid, forward_velocity, turn_rate, drive_mode, saturated,
        output ready);
endinterface

// ----- rtl/core/swv_cfg_if.sv -----
// configuration write channel
interface swv_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/swv_ctrl.sv -----
// valid chain and per-stage load enables of the pipeline
module swv_ctrl import swv_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_ready,
    output logic [PIPE_STAGES-1:0] o_en,
    output logic                   o_valid
);
    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;

    // a stage loads when the output is ready or when it or any stage after it holds a bubble
    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            o_en[k] = i_ready | ~(&(r_valid | ~({PIPE_STAGES{1'b1}} << k)));
        end
        n_valid = r_valid;
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (o_en[k]) begin
                n_valid[k] = (k == 0) ? i_valid : r_valid[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid[PIPE_STAGES-1];
endmodule

// ----- rtl/core/swv_front.sv -----
// front stages: minima, mode decision, products, divisors and rounding offsets
module swv_front import swv_pkg::*; (
    input  logic                    i_clk,
    input  logic [FRONT_STAGES-1:0] i_en,
    input  logic [15:0]             i_gain,
    input  logic [15:0]             i_safe,
    input  logic [15:0]             i_tol,
    input  logic                    i_fresh,
    input  logic [15:0]             i_d0,
    input  logic [15:0]             i_d1,
    input  logic [15:0]             i_d2,
    input  logic [15:0]             i_d3,
    input  logic [15:0]             i_d4,
    input  logic [15:0]             i_d5,
    output logic [VNUM_W-1:0]       o_vnum,
    output logic [VDEN_W-1:0]       o_vden,
    output t_vside                  o_vside,
    output logic [WNUM_W-1:0]       o_wnum,
    output logic [WDEN_W-1:0]       o_wden,
    output t_wside                  o_wside
);
    // stage a
    logic [15:0]        lmin, rmin, big, fmin;
    logic signed [16:0] diff;
    logic [16:0]        absdiff;
    logic               safe;
    t_mode              mode;
    t_mode              r_a_mode;
    logic [15:0]        r_a_big, r_a_small;
    logic signed [16:0] r_a_diff;
    // stage b
    t_mode              r_b_mode;
    logic [15:0]        r_b_big, r_b_small;
    logic [31:0]        r_b_m2;
    logic signed [33:0] r_b_gd;
    // stage c
    t_mode              r_c_mode;
    logic signed [50:0] r_c_vnum;
    logic signed [33:0] r_c_gd;
    logic [VDEN_W-1:0]  r_c_vden;
    logic [WDEN_W-1:0]  r_c_wden;
    logic [VDEN_W-1:0]  vden;
    logic [WDEN_W-1:0]  wden;
    // stage d
    logic signed [50:0] vabs;
    logic signed [33:0] wabs;

    always_comb begin
        lmin = (i_d0 < i_d1) ? i_d0 : i_d1;
        lmin = (lmin < i_d2) ? lmin : i_d2;
        rmin = (i_d3 < i_d4) ? i_d3 : i_d4;
        rmin = (rmin < i_d5) ? rmin : i_d5;
        big  = (i_d2 > i_d3) ? i_d2 : i_d3;
        fmin = (i_d2 < i_d3) ? i_d2 : i_d3;
        diff = $signed({1'b0, lmin}) - $signed({1'b0, rmin});
        absdiff = diff[16] ? 17'(-diff) : 17'(diff);
        safe = (i_d0 > i_safe) && (i_d1 > i_safe) && (i_d2 > i_safe)
            && (i_d3 > i_safe) && (i_d4 > i_safe) && (i_d5 > i_safe);
        priority if (!i_fresh) begin
            mode = MODE_STALE;
        end else if (safe) begin
            mode = MODE_CRUISE;
        end else if (absdiff >= {1'b0, i_tol}) begin
            mode = MODE_CAUTION;
        end else begin
            mode = MODE_DANGER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_mode  <= mode;
            r_a_big   <= big;
            r_a_small <= fmin;
            r_a_diff  <= diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_mode  <= r_a_mode;
            r_b_big   <= r_a_big;
            r_b_small <= r_a_small;
            r_b_m2    <= r_a_big * r_a_big;
            r_b_gd    <= 34'($signed({1'b0, i_gain}) * r_a_diff);
        end
    end

    // cruise divides by 1024*M and 10*M, caution by 2560*M and 2*m
    always_comb begin
        if (r_b_mode == MODE_CRUISE) begin
            vden = VDEN_W'(r_b_big) << 10;
            wden = (WDEN_W'(r_b_big) << 3) + (WDEN_W'(r_b_big) << 1);
        end else begin
            vden = (VDEN_W'(r_b_big) << 11) + (VDEN_W'(r_b_big) << 9);
            wden = WDEN_W'(r_b_small) << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c_mode <= r_b_mode;
            r_c_vnum <= $signed({1'b0, i_gain})
                * ($signed({2'b00, r_b_m2}) - 34'sd65536);
            r_c_gd   <= r_b_gd;
            r_c_vden <= vden;
            r_c_wden <= wden;
        end
    end

    assign vabs = r_c_vnum[50] ? -r_c_vnum : r_c_vnum;
    assign wabs = r_c_gd[33] ? -r_c_gd : r_c_gd;

    // magnitude plus half the divisor gives round half away from zero
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_vnum <= {1'b0, vabs[VNUM_W-2:0]} + VNUM_W'(r_c_vden >> 1);
            o_vden <= r_c_vden;
            o_vside.mode     <= r_c_mode;
            o_vside.neg      <= r_c_vnum[50];
            o_vside.den_zero <= (r_c_vden == '0);
            o_vside.num_nz   <= (r_c_vnum != '0);
            o_wnum <= {1'b0, wabs[WNUM_W-2:0]} + WNUM_W'(r_c_wden >> 1);
            o_wden <= r_c_wden;
            o_wside.neg      <= r_c_gd[33];
            o_wside.den_zero <= (r_c_wden == '0);
            o_wside.num_nz   <= (r_c_gd != '0);
        end
    end
endmodule

// ----- rtl/core/swv_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow detect
module swv_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 28,
    parameter int QW    = 17,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic [QW:0]      i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_side,
    output logic [QW-1:0]    o_q,
    output logic             o_ovf,
    output logic [SB_W-1:0]  o_side
);
    localparam int RW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    logic [RW-1:0]    r_rem  [0:QW];
    logic [DEN_W-1:0] r_den  [0:QW];
    logic [QW-1:0]    r_q    [0:QW];
    logic             r_ovf  [0:QW];
    logic [SB_W-1:0]  r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]  <= RW'(i_num);
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= RW'(i_num) >= (RW'(i_den) << QW);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [RW-1:0] trial;
        logic          take;
        assign trial = RW'(r_den[k-1]) << (QW - k);
        assign take  = r_rem[k-1] >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= take ? r_rem[k-1] - trial : r_rem[k-1];
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= r_q[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_q    = r_q[QW];
    assign o_ovf  = r_ovf[QW];
    assign o_side = r_side[QW];
endmodule

// ----- rtl/core/sonar_wander_velocity_law_top.sv -----
// Sonar wander velocity law: takes one sonar set per cycle unless the output
// stalls a full pipeline, and returns one velocity command per set. The pipeline is
// made of four front stages (minima, two products, rounding), the two 18-stage
// dividers that resolve one quotient bit per stage after a load stage, and one saturation stage.
// Bubbles close up under output stall, so a full pipeline keeps one request
// per cycle when the output is taken every cycle. Configuration writes are
// always taken; index 3 is ignored.
`include "sonar_wander_velocity_law_top_macros.svh"
module sonar_wander_velocity_law_top import swv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    swv_cfg_if.sink   i_cfg,
    swv_in_if.sink    i_in,
    swv_out_if.source o_out
);
    typedef struct packed {
        logic [15:0] val;
        logic        sat;
    } t_sat;

    logic [15:0] r_gain, r_safe, r_tol;
    logic [PIPE_STAGES-1:0] en;
    logic                   out_valid;

    logic [VNUM_W-1:0] vnum;
    logic [VDEN_W-1:0] vden;
    logic [WNUM_W-1:0] wnum;
    logic [WDEN_W-1:0] wden;
    t_vside vside_f, vside_q;
    t_wside wside_f, wside_q;
    logic [Q_W-1:0] vq, wq;
    logic           vovf, wovf;
    t_sat           vres, wres;

    logic [15:0] r_vx, r_wz;
    t_mode       r_mode;
    logic        r_sat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_safe <= SAFE_RST;
            r_tol  <= TOL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GAIN: r_gain <= i_cfg.data;
                CFG_SAFE: r_safe <= i_cfg.data;
                CFG_TOL:  r_tol  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    swv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_ready (o_out.ready),
        .o_en    (en),
        .o_valid (out_valid)
    );

    assign i_in.ready = en[0];

    swv_front u_front (
        .i_clk   (i_clk),
        .i_en    (en[FRONT_STAGES-1:0]),
        .i_gain  (r_gain),
        .i_safe  (r_safe),
        .i_tol   (r_tol),
        .i_fresh (i_in.readings_fresh),
        .i_d0    (i_in.left_outer_dist),
        .i_d1    (i_in.left_mid_dist),
        .i_d2    (i_in.front_left_dist),
        .i_d3    (i_in.front_right_dist),
        .i_d4    (i_in.right_mid_dist),
        .i_d5    (i_in.right_outer_dist),
        .o_vnum  (vnum),
        .o_vden  (vden),
        .o_vside (vside_f),
        .o_wnum  (wnum),
        .o_wden  (wden),
        .o_wside (wside_f)
    );

    swv_div #(.NUM_W(VNUM_W), .DEN_W(VDEN_W), .QW(Q_W), .SB_W($bits(t_vside))) u_vdiv (
        .i_clk  (i_clk),
        .i_en   (en[FRONT_STAGES +: DIV_STAGES]),
        .i_num  (vnum),
        .i_den  (vden),
        .i_side (vside_f),
        .o_q    (vq),
        .o_ovf  (vovf),
        .o_side (vside_q)
    );

    swv_div #(.NUM_W(WNUM_W), .DEN_W(WDEN_W), .QW(Q_W), .SB_W($bits(t_wside))) u_wdiv (
        .i_clk  (i_clk),
        .i_en   (en[FRONT_STAGES +: DIV_STAGES]),
        .i_num  (wnum),
        .i_den  (wden),
        .i_side (wside_f),
        .o_q    (wq),
        .o_ovf  (wovf),
        .o_side (wside_q)
    );

    function automatic t_sat clamp(input logic [Q_W-1:0] q, input logic ovf,
                                   input logic neg, input logic dz, input logic nz);
        t_sat           res;
        logic [Q_W-1:0] qq;
        qq = ovf ? '1 : q;
        if (dz) begin
            res.sat = nz;
            res.val = !nz ? 16'h0000 : (neg ? 16'h8000 : 16'h7FFF);
        end else if (!neg) begin
            res.sat = (qq > Q_W'(32767));
            res.val = res.sat ? 16'h7FFF : qq[15:0];
        end else begin
            res.sat = (qq > Q_W'(32768));
            res.val = res.sat ? 16'h8000 : 16'(-qq);
        end
        return res;
    endfunction

    assign vres = clamp(vq, vovf, vside_q.neg, vside_q.den_zero, vside_q.num_nz);
    assign wres = clamp(wq, wovf, wside_q.neg, wside_q.den_zero, wside_q.num_nz);

    always_ff @(posedge i_clk) begin
        if (en[PIPE_STAGES-1]) begin
            r_mode <= vside_q.mode;
            unique case (vside_q.mode)
                MODE_STALE: begin
                    r_vx  <= '0;
                    r_wz  <= '0;
                    r_sat <= 1'b0;
                end
                MODE_DANGER: begin
                    r_vx  <= DANGER_VX;
                    r_wz  <= DANGER_WZ;
                    r_sat <= 1'b0;
                end
                default: begin
                    r_vx  <= vres.val;
                    r_wz  <= wres.val;
                    r_sat <= vres.sat | wres.sat;
                end
            endcase
        end
    end

    assign o_out.valid            = out_valid;
    assign o_out.forward_velocity = $signed(r_vx);
    assign o_out.turn_rate        = $signed(r_wz);
    assign o_out.drive_mode       = r_mode;
    assign o_out.saturated        = r_sat;

    `SWV_ASSERT_IMP(a_stale_zero, i_clk, i_rst_n, o_out.valid && o_out.drive_mode == MODE_STALE, o_out.forward_velocity == 16'sd0 && o_out.turn_rate == 16'sd0 && !o_out.saturated)
    `SWV_ASSERT_IMP(a_danger_cmd, i_clk, i_rst_n, o_out.valid && o_out.drive_mode == MODE_DANGER, o_out.forward_velocity == $signed(DANGER_VX) && !o_out.saturated)
    `SWV_ASSERT_IMP(a_no_back_pressure, i_clk, i_rst_n, o_out.ready, i_in.ready)
endmodule

// ----- dv/swv_law_checker.sv -----
// checker for the sonar wander velocity law: predicts each command and compares it
module swv_law_checker import swv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    swv_cfg_if   i_cfg,
    swv_in_if    i_in,
    swv_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    typedef struct {
        logic signed [15:0] fwd;
        logic signed [15:0] turn;
        t_mode              mode;
        bit                 sat;
    } t_cmd;

    logic [15:0] gain_q;
    logic [15:0] safe_q;
    logic [15:0] tol_q;
    t_cmd        cmd_queue[$];

    // rounded quotient, ties away from zero, clamped to 16 bits
    function automatic longint quot_sat(longint num, longint den, ref bit sat);
        longint mag;
        longint q;
        if (den <= 0) begin
            if (num == 0) return 0;
            sat = 1;
            return (num < 0) ? -32768 : 32767;
        end
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (q > 40000) q = 40000;
        if (num < 0) q = -q;
        if (q > 32767) begin
            sat = 1;
            return 32767;
        end
        if (q < -32768) begin
            sat = 1;
            return -32768;
        end
        return q;
    endfunction

    function automatic t_cmd wander_law(logic fresh, logic [15:0] d[6]);
        t_cmd   c;
        bit     sat;
        bit     clear;
        longint lmin, rmin, diff, big, lil, vnum;
        sat   = 0;
        clear = 1;
        foreach (d[i]) if (d[i] <= safe_q) clear = 0;
        c.fwd  = 0;
        c.turn = 0;
        c.mode = MODE_STALE;
        if (fresh) begin
            lmin = d[0];
            if (d[1] < lmin) lmin = d[1];
            if (d[2] < lmin) lmin = d[2];
            rmin = d[3];
            if (d[4] < rmin) rmin = d[4];
            if (d[5] < rmin) rmin = d[5];
            diff = lmin - rmin;
            big  = (d[2] > d[3]) ? d[2] : d[3];
            lil  = (d[2] > d[3]) ? d[3] : d[2];
            vnum = longint'(gain_q) * (big * big - 65536);
            if (clear) begin
                c.fwd  = 16'(quot_sat(vnum, 1024 * big, sat));
                c.turn = 16'(quot_sat(longint'(gain_q) * diff, 10 * big, sat));
                c.mode = MODE_CRUISE;
            end else if (((diff < 0) ? -diff : diff) >= longint'(tol_q)) begin
                c.fwd  = 16'(quot_sat(vnum, 2560 * big, sat));
                c.turn = 16'(quot_sat(longint'(gain_q) * diff, 2 * lil, sat));
                c.mode = MODE_CAUTION;
            end else begin
                c.fwd  = DANGER_VX;
                c.turn = DANGER_WZ;
                c.mode = MODE_DANGER;
            end
        end
        c.sat = sat;
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    assign o_pending = cmd_queue.size();

    always @(posedge i_clk) begin
        logic [15:0] d[6];
        t_cmd        want;
        if (!i_rst_n) begin
            gain_q <= GAIN_RST;
            safe_q <= SAFE_RST;
            tol_q  <= TOL_RST;
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_GAIN: gain_q <= i_cfg.data;
                    CFG_SAFE: safe_q <= i_cfg.data;
                    CFG_TOL:  tol_q  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                d = '{i_in.left_outer_dist, i_in.left_mid_dist, i_in.front_left_dist,
                      i_in.front_right_dist, i_in.right_mid_dist, i_in.right_outer_dist};
                cmd_queue.push_back(wander_law(i_in.readings_fresh, d));
            end
            if (i_out.valid && i_out.ready) begin
                if (cmd_queue.size() == 0) begin
                    report_mismatch("unexpected command", 1, 0);
                end else begin
                    want = cmd_queue.pop_front();
                    if (i_out.forward_velocity !== want.fwd)
                        report_mismatch("forward_velocity", i_out.forward_velocity, want.fwd);
                    if (i_out.turn_rate !== want.turn)
                        report_mismatch("turn_rate", i_out.turn_rate, want.turn);
                    if (i_out.drive_mode !== want.mode)
                        report_mismatch("drive_mode", i_out.drive_mode, want.mode);
                    if (i_out.saturated !== want.sat)
                        report_mismatch("saturated", i_out.saturated, want.sat);
                end
            end
        end
    end
endmodule

// ----- dv/sonar_wander_velocity_law_top_tb.sv -----
// testbench top: drives sonar sets and config writes, gives the verdict
module sonar_wander_velocity_law_top_tb;
    import swv_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 40;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    int   idle_cycles;

    swv_cfg_if cfg_ch();
    swv_in_if  in_ch();
    swv_out_if out_ch();

    sonar_wander_velocity_law_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg_ch), .i_in(in_ch), .o_out(out_ch)
    );

    swv_law_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg_ch), .i_in(in_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    logic [15:0] safe_now;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 0;
        if (idx == CFG_SAFE) safe_now = val;
    endtask

    task automatic send_set(logic fresh, logic [15:0] d[6], bit hurry);
        int g;
        g = hurry ? 0 : gap_len();
        if (g > 0) begin
            in_ch.valid = 0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid            = 1;
        in_ch.readings_fresh   = fresh;
        in_ch.left_outer_dist  = d[0];
        in_ch.left_mid_dist    = d[1];
        in_ch.front_left_dist  = d[2];
        in_ch.front_right_dist = d[3];
        in_ch.right_mid_dist   = d[4];
        in_ch.right_outer_dist = d[5];
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_dist();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 700));
            2: return 16'($urandom_range(0, 8));
            3: return 16'(int'(safe_now) + $urandom_range(0, 40) - 20);
            default: return 16'($urandom_range(200, 3000));
        endcase
    endfunction

    task automatic random_set(bit hurry);
        logic [15:0] d[6];
        logic        fresh;
        int          kind;
        fresh = ($urandom_range(0, 7) != 0);
        kind  = $urandom_range(0, 2);
        foreach (d[i]) begin
            if (kind == 0 && safe_now != 16'hFFFF)
                d[i] = 16'($urandom_range(int'(safe_now) + 1, 65535));
            else
                d[i] = rand_dist();
        end
        // unbalanced sides to reach caution, sometimes with a zero front sonar
        if (kind == 1) begin
            d[$urandom_range(0, 2)] = 16'($urandom_range(0, 50));
            if ($urandom_range(0, 5) == 0) d[$urandom_range(2, 3)] = 0;
        end
        send_set(fresh, d, hurry);
    endtask

    // output side: random stalls, and one long hold-off to fill the pipeline
    initial begin
        bit held;
        int r;
        held = 0;
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (!held && sent >= 700) begin
                held = 1;
                out_ch.ready = 0;
                repeat (300) @(negedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 60) out_ch.ready = 1;
            else if (r < 95) out_ch.ready = 0;
            else begin
                out_ch.ready = 0;
                repeat ($urandom_range(5, 40)) @(negedge i_clk);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] d[6];
        logic [15:0] cfgs[6][3];
        sent = 0;
        safe_now = SAFE_RST;
        i_rst_n = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = CFG_GAIN;
        cfg_ch.data  = 0;
        in_ch.valid = 0;
        in_ch.readings_fresh = 0;
        in_ch.left_outer_dist = 0;
        in_ch.left_mid_dist = 0;
        in_ch.front_left_dist = 0;
        in_ch.front_right_dist = 0;
        in_ch.right_mid_dist = 0;
        in_ch.right_outer_dist = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;

        // directed sets under reset settings
        d = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_set(1, d, 0);
        send_set(0, d, 0);
        d = '{0, 0, 0, 0, 0, 0};
        send_set(1, d, 0);
        send_set(0, d, 0);
        d = '{300, 400, 500, 500, 400, 300};
        send_set(1, d, 0);
        d = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 257, 257, 257};
        send_set(1, d, 0);
        d = '{257, 257, 257, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_set(1, d, 0);
        d = '{256, 900, 800, 700, 600, 500};
        send_set(1, d, 0);
        d = '{100, 100, 100, 126, 126, 126};
        send_set(1, d, 0);
        d = '{100, 100, 100, 125, 125, 125};
        send_set(1, d, 0);
        d = '{900, 900, 0, 0, 900, 900};
        send_set(1, d, 0);
        d = '{900, 900, 900, 0, 900, 900};
        send_set(1, d, 0);
        d = '{0, 900, 900, 900, 900, 900};
        send_set(1, d, 0);
        d = '{16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_set(1, d, 0);
        d = '{16'hAAAA, 16'h5555, 16'h8001, 16'h7FFE, 16'h5555, 16'hAAAA};
        send_set(1, d, 0);
        settle();

        cfgs[0] = '{16'hFFFF, 16'h0000, 16'h0000};
        cfgs[1] = '{16'h0000, 16'hFFFF, 16'hFFFF};
        cfgs[2] = '{16'hFFFF, 16'hFFFE, 16'h0001};
        cfgs[3] = '{16'h0040, 16'h0100, 16'h001A};
        cfgs[4] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4000)),
                    16'($urandom_range(0, 600))};
        cfgs[5] = '{16'h0100, 16'h0100, 16'h001A};
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_GAIN, cfgs[p][0]);
            write_reg(CFG_SAFE, cfgs[p][1]);
            write_reg(CFG_TOL, cfgs[p][2]);
            // index 3 is not a register and must change nothing
            write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            // the third phase runs back to back so the long hold-off stalls the input
            for (int k = 0; k < 260; k++) random_set(p == 2);
            settle();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
